[src/b64d_pkg.sv]
// Shared types, codes and the character map of the base64 stream decoder.
`default_nettype none
package b64d_pkg;

  localparam logic [1:0] MODE_STD  = 2'd0;
  localparam logic [1:0] MODE_URL  = 2'd1;
  localparam logic [1:0] MODE_AUTO = 2'd2;
  localparam logic [1:0] MODE_RESET = MODE_AUTO;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD      = 3'd1;
  localparam logic [2:0] ERR_MIXED    = 3'd2;
  localparam logic [2:0] ERR_EMPTY    = 3'd3;
  localparam logic [2:0] ERR_DANGLING = 3'd4;

  localparam logic [7:0] CHAR_PAD = 8'h3D;

  typedef enum logic [1:0] {
    LOCK_NONE = 2'd0,
    LOCK_STD  = 2'd1,
    LOCK_URL  = 2'd2
  } lock_t;

  typedef enum logic [1:0] {
    CLS_BAD     = 2'd0,
    CLS_COMMON  = 2'd1,
    CLS_STD_SYM = 2'd2,
    CLS_URL_SYM = 2'd3
  } char_class_t;

  typedef struct packed {
    logic [1:0] pos;
    logic [5:0] held;
    logic [2:0] err;
    lock_t      lock;
    logic       seen;
  } text_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       byte_ok;
    logic       eot;
    logic [2:0] err;
  } result_t;

  localparam text_state_t STATE_RESET = '{pos: 2'd0, held: 6'd0, err: ERR_NONE,
                                          lock: LOCK_NONE, seen: 1'b0};

  typedef struct packed {
    char_class_t cls;
    logic [5:0]  val;
  } char_map_t;

  // Classify one character and give its sextet value where it has one.
  function automatic char_map_t map_char(input logic [7:0] c);
    char_map_t m;
    m.cls = CLS_BAD;
    m.val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      m.cls = CLS_COMMON;
      m.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      m.cls = CLS_COMMON;
      m.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      m.cls = CLS_COMMON;
      m.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B || c == 8'h2F) begin
      m.cls = CLS_STD_SYM;
      m.val = (c == 8'h2B) ? 6'd62 : 6'd63;
    end else if (c == 8'h2D || c == 8'h5F) begin
      m.cls = CLS_URL_SYM;
      m.val = (c == 8'h2D) ? 6'd62 : 6'd63;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

[src/b64d_step.sv]
// Next-state and result logic for one character of the decoder.
`default_nettype none
module b64d_step (
  input  wire logic [7:0]           in_char,
  input  wire logic                 last_char,
  input  wire logic [1:0]           mode,
  input  wire b64d_pkg::text_state_t cur,
  output b64d_pkg::text_state_t     nxt,
  output b64d_pkg::result_t         res
);

  b64d_pkg::char_map_t   m;
  b64d_pkg::text_state_t upd;
  b64d_pkg::lock_t       fam;
  logic       blank;
  logic       pad;
  logic       fixed;
  logic       sym;
  logic [2:0] err_c;
  logic [5:0] s;
  logic [7:0] data;
  logic       got;

  always_comb begin
    m     = b64d_pkg::map_char(in_char);
    blank = (in_char == 8'h20) || (in_char inside {[8'h09:8'h0D]});
    pad   = (in_char == b64d_pkg::CHAR_PAD);
    fixed = (mode == b64d_pkg::MODE_STD) || (mode == b64d_pkg::MODE_URL);
    sym   = (m.cls == b64d_pkg::CLS_STD_SYM) || (m.cls == b64d_pkg::CLS_URL_SYM);
    fam   = (m.cls == b64d_pkg::CLS_STD_SYM) ? b64d_pkg::LOCK_STD : b64d_pkg::LOCK_URL;
    upd   = cur;
    err_c = b64d_pkg::ERR_NONE;

    if (pad) begin
      if (cur.pos < 2'd2) err_c = b64d_pkg::ERR_BAD;
    end else if (m.cls == b64d_pkg::CLS_BAD) begin
      err_c = b64d_pkg::ERR_BAD;
    end else if (sym) begin
      if (fixed) begin
        if ((mode == b64d_pkg::MODE_STD) != (fam == b64d_pkg::LOCK_STD))
          err_c = b64d_pkg::ERR_BAD;
      end else if (cur.lock == b64d_pkg::LOCK_NONE) begin
        // Auto mode takes the alphabet of the first specific symbol.
        upd.lock = fam;
      end else if (cur.lock != fam) begin
        err_c = b64d_pkg::ERR_MIXED;
      end
    end

    s = pad ? 6'd0 : m.val;
    data = 8'd0;
    got  = 1'b0;
    case (cur.pos)
      2'd1: begin
        data = {cur.held, s[5:4]};
        got  = 1'b1;
      end
      2'd2: begin
        data = {cur.held[3:0], s[5:2]};
        got  = !pad;
      end
      2'd3: begin
        // After a padded third position the held sextet is zero.
        data = {cur.held[1:0], s};
        got  = !pad;
      end
      default: begin
        data = 8'd0;
        got  = 1'b0;
      end
    endcase

    if (!blank) begin
      upd.seen = 1'b1;
      upd.pos  = cur.pos + 2'd1;
      if (err_c == b64d_pkg::ERR_NONE) begin
        upd.held = s;
      end else if (cur.err == b64d_pkg::ERR_NONE) begin
        upd.err = err_c;
      end
    end else begin
      got = 1'b0;
    end
    if (err_c != b64d_pkg::ERR_NONE) got = 1'b0;

    if (last_char && upd.err == b64d_pkg::ERR_NONE) begin
      if (!upd.seen) upd.err = b64d_pkg::ERR_EMPTY;
      else if (upd.pos == 2'd1) upd.err = b64d_pkg::ERR_DANGLING;
    end

    if (upd.err != b64d_pkg::ERR_NONE) got = 1'b0;

    res.data    = got ? data : 8'd0;
    res.byte_ok = got;
    res.eot     = last_char;
    res.err     = upd.err;

    nxt = last_char ? b64d_pkg::STATE_RESET : upd;
  end

endmodule
`default_nettype wire

[src/base64_stream_decoder.sv]
// Top level of the streaming base64 decoder: state, output register and skid word.
//
//   channel  direction  handshake              word
//   in       sink       in_valid / in_stall    in_char, last_char
//   out      source     out_valid / out_stall  out_byte, byte_valid, end_of_text, error_code
//   cfg      sink       cfg_valid / cfg_ready  alphabet_mode
//
// One character is taken per cycle while in_stall is low; its result is registered in the
// output register, or in the skid word if the output is stalled; one word per cycle leaves.
// A skid word holds one result while the output is stalled; in_stall is high only
// while the skid word is full. Reset is synchronous and clears all text state,
// sets the alphabet mode to auto and empties the output side. cfg_ready is always high.
`default_nettype none
module base64_stream_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char,
  input  wire logic       last_char,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            end_of_text,
  output logic [2:0]      error_code,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] alphabet_mode
);

  b64d_pkg::text_state_t st;
  b64d_pkg::text_state_t st_next;
  b64d_pkg::result_t     step_res;
  b64d_pkg::result_t     out_word;
  b64d_pkg::result_t     skid_word;
  logic [1:0] mode;
  logic       skid_valid;
  logic       in_take;
  logic       out_take;

  b64d_step u_step (
    .in_char   (in_char),
    .last_char (last_char),
    .mode      (mode),
    .cur       (st),
    .nxt       (st_next),
    .res       (step_res)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_take   = in_valid && !skid_valid;
  assign out_take  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= b64d_pkg::MODE_RESET;
      st         <= b64d_pkg::STATE_RESET;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (cfg_valid) mode <= alphabet_mode;
      if (in_take) st <= st_next;
      if (skid_valid) begin
        if (out_take) begin
          out_word   <= skid_word;
          skid_valid <= 1'b0;
        end
      end else if (in_take) begin
        if (!out_valid || out_take) begin
          out_word  <= step_res;
          out_valid <= 1'b1;
        end else begin
          skid_word  <= step_res;
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_byte    = out_word.data;
  assign byte_valid  = out_word.byte_ok;
  assign end_of_text = out_word.eot;
  assign error_code  = out_word.err;

endmodule
`default_nettype wire

[src/b64d_checker.sv]
// Port-level checks for the base64 stream decoder, bound to its top level.
`default_nettype none
module b64d_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic       byte_valid,
  input wire logic [2:0] error_code
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(error_code))
    else $error("stalled result word changed");

  // No byte is released in a result word that reports an error.
  a_no_byte_on_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> error_code == b64d_pkg::ERR_NONE)
    else $error("byte released with error set");

  // Without a byte the data field is zero.
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_byte == 8'd0)
    else $error("nonzero data without a byte");

  // Only defined error codes appear.
  a_err_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> error_code <= b64d_pkg::ERR_DANGLING)
    else $error("undefined error code");

  // Reset empties the output side.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .byte_valid (byte_valid),
  .error_code (error_code)
);
`default_nettype wire
